// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 4;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CX_W   = $clog2(COLUMNS);
    localparam int RY_W   = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TPH_W  = $clog2(TAB_STOP);
    localparam int TCNT_W = $clog2(TAB_STOP + 1);

    localparam logic [RY_W:0] ROWS_X = (RY_W + 1)'(ROWS);

    localparam logic [7:0] RESET_COLOR = 8'h07;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    localparam logic REG_DEFAULT_COLOR = 1'b0;

    typedef enum logic [1:0] {
        ACT_PUT,
        ACT_READ,
        ACT_CLEAR,
        ACT_NOP
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL,
        ST_RDA,
        ST_RDD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic              wr_color;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wchr;
        logic [7:0]        wcol;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [RY_W-1:0] phys_row(input logic [RY_W-1:0] row,
                                                 input logic [RY_W-1:0] top);
        logic [RY_W:0] s;
        s = {1'b0, row} + {1'b0, top};
        if (s >= ROWS_X) begin
            s = s - ROWS_X;
        end
        return s[RY_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [RY_W-1:0] row,
                                                    input logic [CX_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

// ===== src/tcce_ram.sv =====
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tcce_seq.sv =====
`timescale 1ns / 1ps

module tcce_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic [7:0]                i_char_code,
    input  logic [6:0]                i_read_col,
    input  logic [4:0]                i_read_row,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [6:0]                o_cursor_col,
    output logic [4:0]                o_cursor_row,
    output logic [10:0]               o_cursor_linear,
    output logic [7:0]                o_read_char,
    output logic [7:0]                o_read_color,
    input  logic [7:0]                i_default_color,
    output tcce_pkg::t_mem_req        o_mem,
    input  logic [7:0]                i_rd_chr,
    input  logic [7:0]                i_rd_col
);

    tcce_pkg::t_state r_state, n_state;

    logic [tcce_pkg::CX_W-1:0]   r_cx, n_cx;
    logic [tcce_pkg::RY_W-1:0]   r_cy, n_cy;
    logic [tcce_pkg::TPH_W-1:0]  r_tph, n_tph;
    logic [tcce_pkg::RY_W-1:0]   r_top, n_top;
    logic [tcce_pkg::ADDR_W-1:0] r_ptr, n_ptr;
    logic                        r_clr_rst, n_clr_rst;
    logic                        r_ov, n_ov;

    logic [tcce_pkg::TCNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]                  r_chr, n_chr;
    logic [6:0]                  r_rc, n_rc;
    logic [4:0]                  r_rr, n_rr;
    logic [7:0]                  r_rch, n_rch;
    logic [7:0]                  r_rco, n_rco;
    logic [6:0]                  r_o_col, n_o_col;
    logic [4:0]                  r_o_row, n_o_row;
    logic [10:0]                 r_o_lin, n_o_lin;
    logic [7:0]                  r_o_rch, n_o_rch;
    logic [7:0]                  r_o_rco, n_o_rco;

    tcce_pkg::t_mem_req mem;
    logic               last_col;
    logic               last_row;
    logic               rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcce_pkg::ST_CLEAR;
            r_cx      <= '0;
            r_cy      <= '0;
            r_tph     <= '0;
            r_top     <= '0;
            r_ptr     <= '0;
            r_clr_rst <= 1'b1;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_tph     <= n_tph;
            r_top     <= n_top;
            r_ptr     <= n_ptr;
            r_clr_rst <= n_clr_rst;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_chr   <= n_chr;
        r_rc    <= n_rc;
        r_rr    <= n_rr;
        r_rch   <= n_rch;
        r_rco   <= n_rco;
        r_o_col <= n_o_col;
        r_o_row <= n_o_row;
        r_o_lin <= n_o_lin;
        r_o_rch <= n_o_rch;
        r_o_rco <= n_o_rco;
    end

    assign last_col = (r_cx == tcce_pkg::CX_W'(tcce_pkg::COLUMNS - 1));
    assign last_row = (r_cy == tcce_pkg::RY_W'(tcce_pkg::ROWS - 1));
    assign rd_ok    = (int'(i_read_col) < tcce_pkg::COLUMNS) &&
                      (int'(i_read_row) < tcce_pkg::ROWS);

    always_comb begin
        n_state   = r_state;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_tph     = r_tph;
        n_top     = r_top;
        n_ptr     = r_ptr;
        n_clr_rst = r_clr_rst;
        n_ov      = r_ov;
        n_cnt     = r_cnt;
        n_chr     = r_chr;
        n_rc      = r_rc;
        n_rr      = r_rr;
        n_rch     = r_rch;
        n_rco     = r_rco;
        n_o_col   = r_o_col;
        n_o_row   = r_o_row;
        n_o_lin   = r_o_lin;
        n_o_rch   = r_o_rch;
        n_o_rco   = r_o_rco;

        mem          = '0;
        mem.raddr    = tcce_pkg::cell_addr(
                           tcce_pkg::phys_row(tcce_pkg::RY_W'(r_rr), r_top),
                           tcce_pkg::CX_W'(r_rc));

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            tcce_pkg::ST_CLEAR: begin
                mem.we       = 1'b1;
                mem.wr_color = 1'b1;
                mem.waddr    = r_ptr;
                mem.wchr     = tcce_pkg::CH_NUL;
                mem.wcol     = r_clr_rst ? tcce_pkg::RESET_COLOR : i_default_color;
                n_ptr        = r_ptr + 1'b1;
                if (r_ptr == tcce_pkg::ADDR_W'(tcce_pkg::CELLS - 1)) begin
                    n_ptr     = '0;
                    n_clr_rst = 1'b0;
                    n_state   = r_clr_rst ? tcce_pkg::ST_IDLE : tcce_pkg::ST_DONE;
                end
            end
            tcce_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_rc  = i_read_col;
                    n_rr  = i_read_row;
                    n_rch = 8'h00;
                    n_rco = 8'h00;
                    n_cnt = '0;
                    n_chr = i_char_code;
                    case (tcce_pkg::t_action'(i_action))
                        tcce_pkg::ACT_PUT: begin
                            case (i_char_code)
                                tcce_pkg::CH_LF: begin
                                    n_cx  = '0;
                                    n_tph = '0;
                                    if (last_row) begin
                                        n_state = tcce_pkg::ST_SCROLL;
                                    end else begin
                                        n_cy    = r_cy + 1'b1;
                                        n_state = tcce_pkg::ST_DONE;
                                    end
                                end
                                tcce_pkg::CH_CR: begin
                                    n_cx    = '0;
                                    n_tph   = '0;
                                    n_state = tcce_pkg::ST_DONE;
                                end
                                tcce_pkg::CH_TAB: begin
                                    n_chr   = tcce_pkg::CH_SPACE;
                                    n_cnt   = tcce_pkg::TCNT_W'(tcce_pkg::TAB_STOP -
                                                                int'(r_tph));
                                    n_state = tcce_pkg::ST_PUT;
                                end
                                default: begin
                                    n_cnt   = tcce_pkg::TCNT_W'(1);
                                    n_state = tcce_pkg::ST_PUT;
                                end
                            endcase
                        end
                        tcce_pkg::ACT_READ: begin
                            n_state = rd_ok ? tcce_pkg::ST_RDA : tcce_pkg::ST_DONE;
                        end
                        tcce_pkg::ACT_CLEAR: begin
                            n_cx    = '0;
                            n_cy    = '0;
                            n_tph   = '0;
                            n_top   = '0;
                            n_ptr   = '0;
                            n_state = tcce_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = tcce_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tcce_pkg::ST_PUT: begin
                mem.we    = 1'b1;
                mem.waddr = tcce_pkg::cell_addr(tcce_pkg::phys_row(r_cy, r_top), r_cx);
                mem.wchr  = r_chr;
                n_cnt     = r_cnt - 1'b1;
                n_state   = (r_cnt == tcce_pkg::TCNT_W'(1)) ? tcce_pkg::ST_DONE
                                                            : tcce_pkg::ST_PUT;
                if (last_col) begin
                    n_cx  = '0;
                    n_tph = '0;
                    if (last_row) begin
                        n_state = tcce_pkg::ST_SCROLL;
                    end else begin
                        n_cy = r_cy + 1'b1;
                    end
                end else begin
                    n_cx  = r_cx + 1'b1;
                    n_tph = (r_tph == tcce_pkg::TPH_W'(tcce_pkg::TAB_STOP - 1)) ? '0
                                                                               : r_tph + 1'b1;
                end
            end
            tcce_pkg::ST_SCROLL: begin
                mem.we       = 1'b1;
                mem.wr_color = 1'b1;
                mem.waddr    = tcce_pkg::cell_addr(r_top, tcce_pkg::CX_W'(r_ptr));
                mem.wchr     = tcce_pkg::CH_NUL;
                mem.wcol     = i_default_color;
                n_ptr        = r_ptr + 1'b1;
                if (r_ptr == tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS - 1)) begin
                    n_ptr   = '0;
                    n_top   = (r_top == tcce_pkg::RY_W'(tcce_pkg::ROWS - 1)) ? '0
                                                                             : r_top + 1'b1;
                    n_state = (r_cnt == '0) ? tcce_pkg::ST_DONE : tcce_pkg::ST_PUT;
                end
            end
            tcce_pkg::ST_RDA: begin
                n_state = tcce_pkg::ST_RDD;
            end
            tcce_pkg::ST_RDD: begin
                n_rch   = i_rd_chr;
                n_rco   = i_rd_col;
                n_state = tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_o_col = 7'(r_cx);
                    n_o_row = 5'(r_cy);
                    n_o_lin = 11'(int'(r_cy) * tcce_pkg::COLUMNS + int'(r_cx));
                    n_o_rch = r_rch;
                    n_o_rco = r_rco;
                    n_state = tcce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcce_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_ready         = (r_state == tcce_pkg::ST_IDLE);
    assign o_valid         = r_ov;
    assign o_cursor_col    = r_o_col;
    assign o_cursor_row    = r_o_row;
    assign o_cursor_linear = r_o_lin;
    assign o_read_char     = r_o_rch;
    assign o_read_color    = r_o_rco;
    assign o_mem           = mem;

endmodule

// ===== src/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Word
// in        i_valid / o_ready      i_action, i_char_code, i_read_col, i_read_row
// out       o_valid / i_ready      o_cursor_col, o_cursor_row, o_cursor_linear,
//                                  o_read_char, o_read_color
// config    psel/penable/pwrite    paddr, pwdata, prdata; pready tied high
//
// Cursor moves, no-ops and reads outside the grid go straight to the result; a read
// inside the grid reads both RAMs, and a put writes n cells (n = 1, or up to TAB_STOP
// for a tab), each scroll clearing a row of COLUMNS cells.
// Scroll rotates a row offset and clears one row; clear sweeps all CELLS entries.
// After reset the grid is swept across all CELLS entries before o_ready rises.
// A waiting result sits in the output register while the next word is accepted.

module text_console_cursor_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_read_col,
    input  logic [4:0]  i_read_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_linear,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_color,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]         r_default_color;
    tcce_pkg::t_mem_req mem;
    logic [7:0]         rd_chr;
    logic [7:0]         rd_col;
    logic               cfg_hit;

    assign cfg_hit = (paddr[2] == tcce_pkg::REG_DEFAULT_COLOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color <= tcce_pkg::RESET_COLOR;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_default_color <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_hit ? {24'h000000, r_default_color} : 32'h00000000;

    tcce_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_read_col      (i_read_col),
        .i_read_row      (i_read_row),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_linear (o_cursor_linear),
        .o_read_char     (o_read_char),
        .o_read_color    (o_read_color),
        .i_default_color (r_default_color),
        .o_mem           (mem),
        .i_rd_chr        (rd_chr),
        .i_rd_col        (rd_col)
    );

    tcce_ram #(
        .WIDTH (8),
        .DEPTH (tcce_pkg::CELLS)
    ) u_chr_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wchr),
        .i_raddr (mem.raddr),
        .o_rdata (rd_chr)
    );

    tcce_ram #(
        .WIDTH (8),
        .DEPTH (tcce_pkg::CELLS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we && mem.wr_color),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wcol),
        .i_raddr (mem.raddr),
        .o_rdata (rd_col)
    );

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem.we |-> !o_ready)
        else $error("grid written while idle");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while busy");

    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cursor_linear ==
            11'(int'(o_cursor_row) * tcce_pkg::COLUMNS + int'(o_cursor_col)))
        else $error("cursor linear mismatch");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_cursor_col) < tcce_pkg::COLUMNS) &&
                    (int'(o_cursor_row) < tcce_pkg::ROWS))
        else $error("cursor outside grid");

endmodule

// ===== tb/console_grid_checker.sv =====
`timescale 1ns / 1ps

module console_grid_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_read_col,
    input  logic [4:0]  i_read_row,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [6:0]  o_cursor_col,
    input  logic [4:0]  o_cursor_row,
    input  logic [10:0] o_cursor_linear,
    input  logic [7:0]  o_read_char,
    input  logic [7:0]  o_read_color,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] COLOR_ADDR = 3'(4 * int'(tcce_pkg::REG_DEFAULT_COLOR));

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] linear;
        logic [7:0]  chr;
        logic [7:0]  color;
    } t_cursor_report;

    logic [7:0]     glyph_mem [tcce_pkg::CELLS];
    logic [7:0]     attr_mem  [tcce_pkg::CELLS];
    int             cur_x;
    int             cur_y;
    logic [7:0]     fill_color;
    t_cursor_report report_q [$];

    task automatic wipe_grid();
        for (int k = 0; k < tcce_pkg::CELLS; k++) begin
            glyph_mem[k] = tcce_pkg::CH_NUL;
            attr_mem[k]  = fill_color;
        end
        cur_x = 0;
        cur_y = 0;
    endtask

    task automatic settle_cursor();
        if (cur_x >= tcce_pkg::COLUMNS) begin
            cur_x = 0;
            cur_y++;
        end
        if (cur_y >= tcce_pkg::ROWS) begin
            for (int k = 0; k < tcce_pkg::CELLS - tcce_pkg::COLUMNS; k++) begin
                glyph_mem[k] = glyph_mem[k + tcce_pkg::COLUMNS];
                attr_mem[k]  = attr_mem[k + tcce_pkg::COLUMNS];
            end
            for (int k = tcce_pkg::CELLS - tcce_pkg::COLUMNS; k < tcce_pkg::CELLS; k++) begin
                glyph_mem[k] = tcce_pkg::CH_NUL;
                attr_mem[k]  = fill_color;
            end
            cur_y = tcce_pkg::ROWS - 1;
        end
    endtask

    task automatic place_glyph(input logic [7:0] code);
        glyph_mem[cur_y * tcce_pkg::COLUMNS + cur_x] = code;
        cur_x++;
        settle_cursor();
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cursor_report want;
        int             spaces;
        int             cell_idx;
        if (!i_rst_n) begin
            fill_color = tcce_pkg::RESET_COLOR;
            wipe_grid();
            report_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == COLOR_ADDR) begin
                fill_color = pwdata[7:0];
            end
            if (o_valid && i_ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual col %0d row %0d",
                             $time, o_cursor_col, o_cursor_row);
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("cursor_col", want.col, o_cursor_col);
                    check_field("cursor_row", want.row, o_cursor_row);
                    check_field("cursor_linear", want.linear, o_cursor_linear);
                    check_field("read_char", want.chr, o_read_char);
                    check_field("read_color", want.color, o_read_color);
                end
            end
            if (i_valid && o_ready) begin
                want = '0;
                case (tcce_pkg::t_action'(i_action))
                    tcce_pkg::ACT_PUT: begin
                        case (i_char_code)
                            tcce_pkg::CH_LF: begin
                                cur_x = 0;
                                cur_y++;
                                settle_cursor();
                            end
                            tcce_pkg::CH_CR: begin
                                cur_x = 0;
                            end
                            tcce_pkg::CH_TAB: begin
                                spaces = tcce_pkg::TAB_STOP - (cur_x % tcce_pkg::TAB_STOP);
                                repeat (spaces) place_glyph(tcce_pkg::CH_SPACE);
                            end
                            default: begin
                                place_glyph(i_char_code);
                            end
                        endcase
                    end
                    tcce_pkg::ACT_READ: begin
                        if (int'(i_read_col) < tcce_pkg::COLUMNS &&
                            int'(i_read_row) < tcce_pkg::ROWS) begin
                            cell_idx   = int'(i_read_row) * tcce_pkg::COLUMNS +
                                         int'(i_read_col);
                            want.chr   = glyph_mem[cell_idx];
                            want.color = attr_mem[cell_idx];
                        end
                    end
                    tcce_pkg::ACT_CLEAR: begin
                        wipe_grid();
                    end
                    default: begin
                    end
                endcase
                want.col    = 7'(cur_x);
                want.row    = 5'(cur_y);
                want.linear = 11'(cur_y * tcce_pkg::COLUMNS + cur_x);
                report_q.push_back(want);
            end
        end
        pending = report_q.size();
    end

endmodule

// ===== tb/text_console_cursor_engine_test.sv =====
`timescale 1ns / 1ps

module text_console_cursor_engine_test;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_char_code;
    logic [6:0]  i_read_col;
    logic [4:0]  i_read_row;
    logic        o_valid;
    logic        i_ready;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic [10:0] o_cursor_linear;
    logic [7:0]  o_read_char;
    logic [7:0]  o_read_color;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          calm;
    int          stall_cycles;

    text_console_cursor_engine u_dut (.*);

    console_grid_checker u_checker (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 17);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("text_console_cursor_engine test failed");
            $finish;
        end
    end

    task automatic send_word(input tcce_pkg::t_action act, input logic [7:0] code,
                             input logic [6:0] col, input logic [4:0] row);
        while (!calm && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_char_code <= code;
        i_read_col  <= col;
        i_read_row  <= row;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_default_color(input logic [7:0] shade);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(tcce_pkg::REG_DEFAULT_COLOR));
        pwdata  <= {24'(0), shade};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        tcce_pkg::t_action act;
        logic [7:0]        code;
        logic [6:0]        col;
        logic [4:0]        row;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            if (pick < 3) begin
                act = tcce_pkg::ACT_CLEAR;
            end else if (pick < 30) begin
                act = tcce_pkg::ACT_NOP;
            end else if (pick < 150) begin
                act = tcce_pkg::ACT_READ;
            end else begin
                act = tcce_pkg::ACT_PUT;
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                code = tcce_pkg::CH_LF;
            end else if (pick < 16) begin
                code = tcce_pkg::CH_CR;
            end else if (pick < 24) begin
                code = tcce_pkg::CH_TAB;
            end else if (pick < 80) begin
                code = 8'($urandom_range(126, 32));
            end else begin
                code = 8'($urandom);
            end
            if ($urandom_range(3) == 0) begin
                col = 7'($urandom);
                row = 5'($urandom);
            end else begin
                col = 7'($urandom_range(tcce_pkg::COLUMNS - 1));
                row = 5'($urandom_range(tcce_pkg::ROWS - 1));
            end
            send_word(act, code, col, row);
        end
    endtask

    initial begin
        logic [7:0] shades [6];
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = tcce_pkg::ACT_NOP;
        i_char_code  = tcce_pkg::CH_NUL;
        i_read_col   = '0;
        i_read_row   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        shades       = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h00};
        shades[5]    = 8'($urandom);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_READ, 8'hFF, 7'd79, 5'd24);
        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd127, 5'd31);
        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd80, 5'd3);
        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd5, 5'd25);
        send_word(tcce_pkg::ACT_NOP, 8'hFF, 7'd127, 5'd31);
        send_word(tcce_pkg::ACT_PUT, 8'h41, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, tcce_pkg::CH_NUL, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, 8'hFF, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, 8'h01, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, tcce_pkg::CH_TAB, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, 8'h7E, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, tcce_pkg::CH_TAB, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_PUT, tcce_pkg::CH_CR, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd4, 5'd0);
        send_word(tcce_pkg::ACT_PUT, tcce_pkg::CH_LF, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_CLEAR, tcce_pkg::CH_NUL, 7'd0, 5'd0);
        repeat (tcce_pkg::ROWS) send_word(tcce_pkg::ACT_PUT, tcce_pkg::CH_LF, 7'd0, 5'd0);
        send_word(tcce_pkg::ACT_READ, tcce_pkg::CH_NUL, 7'd0, 5'd24);

        for (int p = 0; p < 6; p++) begin
            drain();
            write_default_color(shades[p]);
            calm = (p == 3);
            if (p % 2 == 0) begin
                send_word(tcce_pkg::ACT_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
            end
            run_phase(300);
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("text_console_cursor_engine test passed");
        end else begin
            $display("text_console_cursor_engine test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tcce_pkg.sv
src/tcce_ram.sv
src/tcce_seq.sv
src/text_console_cursor_engine.sv
tb/console_grid_checker.sv
tb/text_console_cursor_engine_test.sv
